// File: rtl/swer_pkg.sv
// shared types and constants for the sliding window event rate unit
// no dependencies; imported by the top level and the port checker
package swer_pkg;

   localparam int unsigned TIME_W      = 32;
   localparam int unsigned RETENTION_W = 20;
   localparam int unsigned RATE_W      = 9;
   localparam int unsigned TOTAL_W     = 32;

   localparam logic [TIME_W:0]        WINDOW_MS       = 33'd1000;
   localparam logic [RATE_W-1:0]      RATE_MAX        = 9'd511;
   localparam logic [RETENTION_W-1:0] RETENTION_RESET = 20'd60000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_EVICT,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/swer_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; holds the timestamp ring of the event rate unit
module swer_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// File: rtl/sliding_window_event_rate_unit.sv
// flow: a transfer goes from idle through the prime, evict and scan states to finish, where
//   the result is registered; a held entry may be evicted or scanned, never both
// one item at a time: the unit returns to idle as the result is registered and only then
//   takes the next transfer; a previous result still stalled holds the unit in its last state
// reset: synchronous, active high; clears ring pointers, counters, peak and output valid,
//   sets retention_ms to 60000; ring contents are not cleared and need no clearing pass
module sliding_window_event_rate_unit #(
   parameter int unsigned RING_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [swer_pkg::RETENTION_W-1:0]    csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [swer_pkg::TIME_W-1:0]         req_event_time,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [swer_pkg::TOTAL_W-1:0]        rsp_total_events,
   output logic [swer_pkg::RATE_W-1:0]         rsp_window_rate,
   output logic [swer_pkg::RATE_W-1:0]         rsp_peak_rate
);

   import swer_pkg::*;

   localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [AW:0]   DEPTH_C = (AW+1)'(RING_DEPTH);
   localparam logic [AW-1:0] LAST_C  = AW'(RING_DEPTH - 1);

   state_type state_ff, state_in;

   logic [TIME_W-1:0]      now_ff, now_in;
   logic [RETENTION_W-1:0] retention_ff;
   logic [AW-1:0]          oldest_ff, oldest_in;
   logic [AW:0]            held_ff, held_in;
   logic [AW-1:0]          ptr_ff, ptr_in;
   logic [AW:0]            left_ff, left_in;
   logic [RATE_W-1:0]      count_ff, count_in;
   logic                   counting_ff, counting_in;
   logic [TOTAL_W-1:0]     total_ff, total_in;
   logic [RATE_W-1:0]      peak_ff, peak_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0]     rsp_total_ff, rsp_total_in;
   logic [RATE_W-1:0]      rsp_rate_ff, rsp_rate_in;
   logic [RATE_W-1:0]      rsp_peak_ff, rsp_peak_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [AW-1:0]     ram_raddr;
   logic [TIME_W-1:0] ram_rdata;

   logic          full;
   logic [AW-1:0] oldest_next;
   logic [AW-1:0] ptr_next;
   logic [AW:0]   append_sum;
   logic [AW-1:0] append_addr;
   logic          stale;
   logic          below_start;
   logic          below_now;
   logic          scan_hit;
   logic          out_free;
   logic [RATE_W-1:0] peak_max;

   swer_ram #(
      .WIDTH (TIME_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (ram_waddr),
      .write_data   (req_event_time),
      .read_addr    (ram_raddr),
      .read_data    (ram_rdata)
   );

   assign full        = (held_ff == DEPTH_C);
   assign oldest_next = (oldest_ff == LAST_C) ? '0 : oldest_ff + 1'b1;
   assign ptr_next    = (ptr_ff == LAST_C) ? '0 : ptr_ff + 1'b1;
   assign append_sum  = {1'b0, oldest_ff} + held_ff;
   assign append_addr = (append_sum >= DEPTH_C) ? AW'(append_sum - DEPTH_C)
                                                : append_sum[AW-1:0];

   // widened compares, so early times and large retentions never wrap
   assign stale       = ({1'b0, ram_rdata} + (TIME_W+1)'(retention_ff)) < {1'b0, now_ff};
   assign below_start = ({1'b0, ram_rdata} + WINDOW_MS) < {1'b0, now_ff};
   assign below_now   = ram_rdata < now_ff;
   assign scan_hit    = counting_ff || !below_start;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign peak_max    = (count_ff > peak_ff) ? count_ff : peak_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            state_in = ST_EVICT;
         end
         ST_EVICT: begin
            if (!stale) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((scan_hit && !below_now) || left_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      now_in       = now_ff;
      oldest_in    = oldest_ff;
      held_in      = held_ff;
      ptr_in       = ptr_ff;
      left_in      = left_ff;
      count_in     = count_ff;
      counting_in  = counting_ff;
      total_in     = total_ff;
      peak_in      = peak_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_total_in = rsp_total_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_peak_in  = rsp_peak_ff;
      ram_we       = 1'b0;
      ram_waddr    = full ? oldest_ff : append_addr;
      ram_raddr    = oldest_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ram_we   = 1'b1;
               now_in   = req_event_time;
               total_in = total_ff + 1'b1;
               // full ring: new stamp replaces the oldest one
               if (full) begin
                  oldest_in = oldest_next;
               end else begin
                  held_in = held_ff + 1'b1;
               end
            end
         end
         ST_PRIME: begin
            ram_raddr = oldest_ff;
         end
         ST_EVICT: begin
            if (stale) begin
               oldest_in = oldest_next;
               held_in   = held_ff - 1'b1;
               ram_raddr = oldest_next;
            end else begin
               ram_raddr   = oldest_ff;
               ptr_in      = oldest_ff;
               left_in     = held_ff - 1'b1;
               count_in    = '0;
               counting_in = 1'b0;
            end
         end
         ST_SCAN: begin
            ram_raddr = ptr_next;
            ptr_in    = ptr_next;
            left_in   = left_ff - 1'b1;
            // skip entries before the window, then count the run below now
            if (scan_hit) begin
               counting_in = 1'b1;
               if (below_now && count_ff != RATE_MAX) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               peak_in      = peak_max;
               rsp_valid_in = 1'b1;
               rsp_total_in = total_ff;
               rsp_rate_in  = count_ff;
               rsp_peak_in  = peak_max;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         retention_ff <= RETENTION_RESET;
         oldest_ff    <= '0;
         held_ff      <= '0;
         total_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_total_ff <= '0;
         rsp_rate_ff  <= '0;
         rsp_peak_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         held_ff      <= held_in;
         total_ff     <= total_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_total_ff <= rsp_total_in;
         rsp_rate_ff  <= rsp_rate_in;
         rsp_peak_ff  <= rsp_peak_in;
         if (csr_write_enable) begin
            retention_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      ptr_ff      <= ptr_in;
      left_ff     <= left_in;
      count_ff    <= count_in;
      counting_ff <= counting_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_total_events = rsp_total_ff;
   assign rsp_window_rate  = rsp_rate_ff;
   assign rsp_peak_rate    = rsp_peak_ff;

endmodule

// File: rtl/swer_checker.sv
// port-level checks for the sliding window event rate unit, bound to the top level
// depends on swer_pkg
module swer_checker #(
   parameter int unsigned RING_DEPTH = 256
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [swer_pkg::TOTAL_W-1:0]     rsp_total_events,
   input logic [swer_pkg::RATE_W-1:0]      rsp_window_rate,
   input logic [swer_pkg::RATE_W-1:0]      rsp_peak_rate
);

   import swer_pkg::*;

   localparam logic [17:0] DEPTH_C = 18'(RING_DEPTH);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_total_events)
         && $stable(rsp_window_rate) && $stable(rsp_peak_rate))
      else $error("stalled result changed");

   // one item in flight: input stalls right after a transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_peak_rate >= rsp_window_rate)
      else $error("peak below window rate");

   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> rsp_peak_rate >= $past(rsp_peak_rate))
      else $error("peak rate decreased");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {9'd0, rsp_window_rate} <= DEPTH_C)
      else $error("window rate exceeds ring depth");

endmodule

bind sliding_window_event_rate_unit swer_checker #(.RING_DEPTH(RING_DEPTH)) u_checker (.*);

// File: tb/tb_sliding_window_event_rate_unit.sv
// self-checking testbench for sliding_window_event_rate_unit: a behavioral copy of the
// timestamp ring predicts every result, directed and random stimulus with random stalls
// depends on swer_pkg and the rtl of the unit
`timescale 1ns / 1ps

module tb_sliding_window_event_rate_unit;

   localparam int unsigned RING_DEPTH = 256;
   localparam int unsigned RATE_LIMIT = 511;
   localparam longint     WINDOW_LEN = 1000;

   typedef logic [swer_pkg::TIME_W-1:0]      stamp_type;
   typedef logic [swer_pkg::RETENTION_W-1:0] retention_type;

   typedef struct {
      logic [swer_pkg::TOTAL_W-1:0] total_events;
      logic [swer_pkg::RATE_W-1:0]  window_rate;
      logic [swer_pkg::RATE_W-1:0]  peak_rate;
   } rate_result_type;

   logic          clock;
   logic          reset;
   logic          csr_write_enable;
   retention_type csr_write_data;
   logic          req_valid;
   logic          req_stall;
   stamp_type     req_event_time;
   logic          rsp_valid;
   logic          rsp_stall;
   logic [swer_pkg::TOTAL_W-1:0] rsp_total_events;
   logic [swer_pkg::RATE_W-1:0]  rsp_window_rate;
   logic [swer_pkg::RATE_W-1:0]  rsp_peak_rate;

   // behavioral copy of the unit's state
   stamp_type                    ring_stamps [RING_DEPTH];
   int unsigned                  ring_head;
   int unsigned                  ring_held;
   logic [swer_pkg::TOTAL_W-1:0] seen_total;
   logic [swer_pkg::RATE_W-1:0]  seen_peak;
   retention_type                held_retention;

   rate_result_type pending_rates [$];
   int unsigned     mismatch_count;
   int unsigned     send_idle_pct;
   int unsigned     recv_idle_pct;
   stamp_type       stream_time;

   sliding_window_event_rate_unit #(
      .RING_DEPTH(RING_DEPTH)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_event_time   (req_event_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_total_events (rsp_total_events),
      .rsp_window_rate  (rsp_window_rate),
      .rsp_peak_rate    (rsp_peak_rate)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb_sliding_window_event_rate_unit failed");
      $finish;
   end

   function automatic longint stamp_at(input int unsigned offset);
      return longint'({32'd0, ring_stamps[(ring_head + offset) % RING_DEPTH]});
   endfunction

   task automatic predict_rate(input stamp_type stamp);
      longint          now_l;
      longint          start_l;
      int unsigned     skip;
      int unsigned     hits;
      rate_result_type r;
      now_l   = longint'({32'd0, stamp});
      start_l = now_l - WINDOW_LEN;
      seen_total = seen_total + 1'b1;
      if (ring_held >= RING_DEPTH) begin
         ring_stamps[ring_head] = stamp;
         ring_head = (ring_head + 1) % RING_DEPTH;
      end else begin
         ring_stamps[(ring_head + ring_held) % RING_DEPTH] = stamp;
         ring_held++;
      end
      while (ring_held > 0 && stamp_at(0) + longint'({44'd0, held_retention}) < now_l) begin
         ring_head = (ring_head + 1) % RING_DEPTH;
         ring_held--;
      end
      skip = 0;
      while (skip < ring_held && stamp_at(skip) < start_l) skip++;
      hits = 0;
      if (skip < ring_held) begin
         while (skip + hits < ring_held && stamp_at(skip + hits) < now_l) hits++;
      end
      if (hits > RATE_LIMIT) hits = RATE_LIMIT;
      if (hits > seen_peak) seen_peak = 9'(hits);
      r.total_events = seen_total;
      r.window_rate  = 9'(hits);
      r.peak_rate    = seen_peak;
      pending_rates.push_back(r);
   endtask

   // valid drops after a transfer; the unit takes one item at a time
   task automatic send_stamp(input stamp_type stamp);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid      = 1'b0;
         req_event_time = $urandom();
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_event_time = stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_rate(stamp);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_rates.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_retention(input retention_type value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      held_retention   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // receiver side: stall drawn every cycle
   initial begin
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      rate_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rates.size() == 0) begin
            $error("result transfer with no expected result: total_events %0d", rsp_total_events);
            mismatch_count++;
         end else begin
            want = pending_rates.pop_front();
            if (rsp_total_events !== want.total_events) begin
               $error("total_events expected %0d actual %0d", want.total_events, rsp_total_events);
               mismatch_count++;
            end
            if (rsp_window_rate !== want.window_rate) begin
               $error("window_rate expected %0d actual %0d", want.window_rate, rsp_window_rate);
               mismatch_count++;
            end
            if (rsp_peak_rate !== want.peak_rate) begin
               $error("peak_rate expected %0d actual %0d", want.peak_rate, rsp_peak_rate);
               mismatch_count++;
            end
         end
      end
   end

   // reset retention, equal stamps, early times, top of the time range, out-of-order stamps
   task automatic test_directed_edges();
      stamp_type list [$];
      list = {32'd0, 32'd0, 32'd1, 32'd999, 32'd1000, 32'd1000, 32'd1001, 32'd1999,
              32'd2000, 32'd2500, 32'h8000_0000, 32'hFFFF_FC17, 32'hFFFF_FFFE,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5, 32'h5555_5555, 32'hAAAA_AAAA};
      foreach (list[k]) send_stamp(list[k]);
      drain_results();
   endtask

   // zero retention drops everything older than now, the widest keeps stamps within 1048575 of now
   task automatic test_retention_extremes();
      stamp_type list [$];
      write_retention('0);
      list = {32'd100, 32'd100, 32'd100, 32'd101, 32'd101, 32'd102, 32'd50};
      foreach (list[k]) send_stamp(list[k]);
      drain_results();
      write_retention('1);
      list = {32'd200, 32'd700, 32'd1199, 32'd1200, 32'd1201, 32'd1_048_900};
      foreach (list[k]) send_stamp(list[k]);
      drain_results();
      write_retention(20'd1500);
      list = {32'd1_050_000, 32'd1_050_800, 32'd1_051_600, 32'd1_052_300, 32'd1_053_000};
      foreach (list[k]) send_stamp(list[k]);
      drain_results();
   endtask

   // overfill the ring with a dense burst, then let the window empty
   task automatic test_ring_wrap();
      stamp_type base;
      write_retention('1);
      base = 32'h0123_4000;
      for (int k = 0; k < RING_DEPTH + 24; k++) send_stamp(base + 3 * k);
      send_stamp(base + 3 * (RING_DEPTH + 24) + 100);
      send_stamp(base + 5000);
      send_stamp(base + 5000);
      drain_results();
   endtask

   function automatic stamp_type next_stamp();
      int unsigned pick;
      logic [32:0] sum;
      pick = $urandom_range(99);
      if (pick < 5) return $urandom();
      if (pick < 8) sum = {1'b0, stream_time} + $urandom();
      else if (pick < 40) sum = {1'b0, stream_time} + $urandom_range(3);
      else if (pick < 80) sum = {1'b0, stream_time} + $urandom_range(60, 1);
      else sum = {1'b0, stream_time} + $urandom_range(1500, 100);
      if (sum[32]) stream_time = $urandom_range(5000);
      else stream_time = sum[31:0];
      return stream_time;
   endfunction

   task automatic test_random_stream(input int unsigned send_pct, input int unsigned recv_pct,
                                     input retention_type retention, input int unsigned count);
      write_retention(retention);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int unsigned k = 0; k < count; k++) begin
         // hold off the sender until the unit has caught up
         if (k == count / 2 || $urandom_range(99) == 0) drain_results();
         send_stamp(next_stamp());
      end
      drain_results();
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_event_time   = '0;
      rsp_stall        = 1'b0;
      ring_head        = 0;
      ring_held        = 0;
      seen_total       = '0;
      seen_peak        = '0;
      held_retention   = swer_pkg::RETENTION_RESET;
      mismatch_count   = 0;
      send_idle_pct    = 37;
      recv_idle_pct    = 64;
      stream_time      = 32'd10_000;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_edges();
      test_retention_extremes();
      test_ring_wrap();
      test_random_stream(37, 64, retention_type'($urandom_range(3000, 400)), 60);
      test_random_stream(64, 37, '1, 60);
      test_random_stream(0, 0, retention_type'($urandom()), 60);

      drain_results();
      repeat (2 * RING_DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && pending_rates.size() == 0) begin
         $display("tb_sliding_window_event_rate_unit passed");
      end else begin
         $display("tb_sliding_window_event_rate_unit failed");
      end
      $finish;
   end

endmodule
